// ----- rtl/wsd_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

  localparam int LENGTH_BITS_DEF = 64;
  localparam int MAX_LEN_W       = 20;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 20'd1000000;

  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERSIZE = 2'd1;
  localparam logic [1:0] ST_CLOSE    = 2'd2;
  localparam logic [1:0] ST_PING     = 2'd3;

  // One result beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic [3:0] frame_opcode;
    logic       frame_fin;
    logic [1:0] status;
  } result_t;

endpackage

// ----- rtl/wsd_in_reg.sv -----
// Input register stage: holds one received byte until the parser takes it.
module wsd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic load;

  assign in_stall = held_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_byte <= in_byte;
    end
  end

endmodule

// ----- rtl/wsd_parser.sv -----
// Frame parser: header, extended length and payload tracking, one byte per step.
module wsd_parser #(
  parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [7:0]                      byte_in,
  input  logic [wsd_pkg::MAX_LEN_W-1:0]   max_len,
  output logic                            res_valid,
  output wsd_pkg::result_t                res
);
  import wsd_pkg::*;

  localparam int CMP_W = (LENGTH_BITS > MAX_LEN_W) ? LENGTH_BITS : MAX_LEN_W;

  typedef enum logic [1:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_PAYLOAD
  } phase_t;

  phase_t                 phase, phase_next;
  logic [3:0]             held_opcode, held_opcode_next;
  logic                   held_fin, held_fin_next;
  logic [3:0]             ext_left, ext_left_next;
  logic [LENGTH_BITS-1:0] accum, accum_next;
  logic [LENGTH_BITS-1:0] remaining, remaining_next;
  logic                   discard, discard_next;
  logic                   closed, closed_next;

  logic                   len_known;
  logic [LENGTH_BITS-1:0] known_len;
  logic [LENGTH_BITS-1:0] accum_shift;
  logic                   emit;

  always_comb begin
    phase_next       = phase;
    held_opcode_next = held_opcode;
    held_fin_next    = held_fin;
    ext_left_next    = ext_left;
    accum_next       = accum;
    remaining_next   = remaining;
    discard_next     = discard;
    closed_next      = closed;
    len_known        = 1'b0;
    known_len        = '0;
    emit             = 1'b0;
    res              = '0;
    res.frame_opcode = held_opcode;
    res.frame_fin    = held_fin;

    // Saturate once the next shift would push bits past the top.
    if (accum[LENGTH_BITS-1 -: 8] != 8'd0) begin
      accum_shift = '1;
    end else begin
      accum_shift = {accum[LENGTH_BITS-9:0], byte_in};
    end

    case (phase)
      PH_HDR0: begin
        held_fin_next    = byte_in[7];
        held_opcode_next = byte_in[3:0];
        phase_next       = PH_HDR1;
      end
      PH_HDR1: begin
        if (byte_in[6:0] == LEN7_EXT16 || byte_in[6:0] == LEN7_EXT64) begin
          ext_left_next = (byte_in[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          accum_next    = '0;
          phase_next    = PH_EXT;
        end else begin
          len_known = 1'b1;
          known_len = LENGTH_BITS'(byte_in[6:0]);
        end
      end
      PH_EXT: begin
        accum_next    = accum_shift;
        ext_left_next = ext_left - 4'd1;
        if (ext_left_next == 4'd0) begin
          len_known = 1'b1;
          known_len = accum_shift;
        end
      end
      PH_PAYLOAD: begin
        remaining_next = remaining - LENGTH_BITS'(1);
        if (remaining_next == '0) begin
          phase_next = PH_HDR0;
        end
        if (!discard) begin
          emit           = 1'b1;
          res.out_byte   = byte_in;
          res.byte_valid = 1'b1;
          res.last       = (remaining_next == '0);
        end
      end
      default: begin
        phase_next = PH_HDR0;
      end
    endcase

    if (len_known) begin
      remaining_next = known_len;
      phase_next     = (known_len == '0) ? PH_HDR0 : PH_PAYLOAD;
      if (CMP_W'(known_len) > CMP_W'(max_len)) begin
        discard_next = 1'b1;
        emit         = 1'b1;
        res.last     = 1'b1;
        res.status   = ST_OVERSIZE;
      end else if (held_opcode == OP_CLOSE) begin
        discard_next = 1'b1;
        closed_next  = 1'b1;
        emit         = 1'b1;
        res.last     = 1'b1;
        res.status   = ST_CLOSE;
      end else if (held_opcode == OP_PING) begin
        discard_next = 1'b1;
        emit         = 1'b1;
        res.last     = 1'b1;
        res.status   = ST_PING;
      end else begin
        discard_next = 1'b0;
        if (known_len == '0) begin
          emit     = 1'b1;
          res.last = 1'b1;
        end
      end
    end
  end

  // Drop every byte once the link is closed.
  assign res_valid = emit && !closed;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR0;
      held_opcode <= '0;
      held_fin    <= 1'b0;
      ext_left    <= '0;
      accum       <= '0;
      remaining   <= '0;
      discard     <= 1'b0;
      closed      <= 1'b0;
    end else if (step && !closed) begin
      phase       <= phase_next;
      held_opcode <= held_opcode_next;
      held_fin    <= held_fin_next;
      ext_left    <= ext_left_next;
      accum       <= accum_next;
      remaining   <= remaining_next;
      discard     <= discard_next;
      closed      <= closed_next;
    end
  end

endmodule

// ----- rtl/wsd_out_reg.sv -----
// Result register: holds one result beat until the downstream side takes it.
module wsd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             res_valid,
  input  wsd_pkg::result_t res,
  output logic             can_advance,
  output logic             out_valid,
  input  logic             out_stall,
  output wsd_pkg::result_t out_res
);

  assign can_advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

endmodule

// ----- rtl/websocket_frame_deframer_top.sv -----
// Top level of the WebSocket frame deframer.
// Parses a received WebSocket byte stream, one byte per beat. A byte sits in
// an input register, the parser updates its frame state from it, and any
// result lands in a result register, so a new byte is taken every cycle while
// the output keeps up: throughput is one byte per cycle. Header bytes and
// extended-length bytes give no payload beat. Data-frame payload bytes come
// out with byte_valid set and last on the final byte; an empty data frame
// gives one beat with byte_valid low and last high. When the frame length is
// known, an oversize frame (longer than max_payload_len) gives a status 1
// beat and its payload is skipped; otherwise a close frame gives a status 2
// beat and latches the link closed, after which every byte is dropped until
// reset; a ping gives a status 3 beat and its payload is skipped. Extended
// lengths that overflow LENGTH_BITS saturate to all ones. max_payload_len is
// written through cfg_wr_en/cfg_wr_data and should only change while the
// block is idle.
module websocket_frame_deframer_top #(
  parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [wsd_pkg::MAX_LEN_W-1:0] cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic                          byte_valid,
  output logic                          last,
  output logic [3:0]                    frame_opcode,
  output logic                          frame_fin,
  output logic [1:0]                    status
);
  import wsd_pkg::*;

  logic [MAX_LEN_W-1:0] max_payload_len;
  logic                 held_valid;
  logic [7:0]           held_byte;
  logic                 can_advance;
  logic                 advance;
  logic                 res_valid;
  result_t              res;
  result_t              out_res;

  // Configuration register; reset to the default limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_payload_len <= cfg_wr_data;
    end
  end

  // Advance the held byte whenever the result register has room.
  assign advance = held_valid && can_advance;

  wsd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  wsd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .byte_in   (held_byte),
    .max_len   (max_payload_len),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .res_valid   (res_valid),
    .res         (res),
    .can_advance (can_advance),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (out_res)
  );

  assign out_byte     = out_res.out_byte;
  assign byte_valid   = out_res.byte_valid;
  assign last         = out_res.last;
  assign frame_opcode = out_res.frame_opcode;
  assign frame_fin    = out_res.frame_fin;
  assign status       = out_res.status;

endmodule
